[rtl/ltmd_pkg.sv]
// ----------------------------------------------------------------------------
// Length-table message deframer package
// Shared beat types, field codes and sizing constants for the deframer.
// ----------------------------------------------------------------------------
package ltmd_pkg;

   localparam int MAX_PARAMS = 16;
   localparam int IDX_W      = $clog2(MAX_PARAMS);
   localparam int CNT_W      = $clog2(MAX_PARAMS + 1);
   localparam int POS_W      = 4;

   localparam logic [CNT_W-1:0] MAX_PARAMS_CNT = CNT_W'(MAX_PARAMS);
   localparam logic [IDX_W-1:0] LAST_PARAM_IDX = IDX_W'(MAX_PARAMS - 1);

   localparam logic [15:0]      TERMINATOR_WORD = 16'hFFFF;
   localparam logic [POS_W-1:0] MIN_FRAME       = POS_W'(8);
   localparam logic [POS_W-1:0] HEADER_BYTES    = POS_W'(6);
   localparam logic [POS_W-1:0] LAST_CMD_POS    = POS_W'(3);

   // Byte kinds.
   localparam logic [2:0] KIND_TYPE       = 3'd0;
   localparam logic [2:0] KIND_COMMAND    = 3'd1;
   localparam logic [2:0] KIND_VERSION    = 3'd2;
   localparam logic [2:0] KIND_LENGTH     = 3'd3;
   localparam logic [2:0] KIND_TERMINATOR = 3'd4;
   localparam logic [2:0] KIND_DATA       = 3'd5;
   localparam logic [2:0] KIND_TRAILING   = 3'd6;

   // Frame status codes.
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_TOO_SHORT  = 3'd1;
   localparam logic [2:0] STATUS_NO_TERM    = 3'd2;
   localparam logic [2:0] STATUS_TRUNCATED  = 3'd3;
   localparam logic [2:0] STATUS_TOO_MANY   = 3'd4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic [2:0]       kind;
      logic [IDX_W-1:0] param_index;
      logic             param_byte_last;
      logic             frame_done;
      logic [2:0]       status;
      logic [CNT_W-1:0] param_count;
   } rsp_type;

endpackage

[rtl/length_table_message_deframer_core.sv]
// ----------------------------------------------------------------------------
// Length-table message deframer
// Labels each byte of a frame as header, length word, terminator, parameter
// data or trailing, and reports a status and parameter count on the last byte.
// ----------------------------------------------------------------------------
// Latency: each result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the result side is ready; the result register and the frame state
// update together, so a new beat is taken while the previous result is taken.
// Reset: synchronous; clears the frame state and the result valid. The
// parameter length table holds no reset value and is only used once written.
module length_table_message_deframer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ltmd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ltmd_pkg::rsp_type rsp_data
);

   logic              step;
   ltmd_pkg::rsp_type rsp_next;

   assign step = req_valid && req_ready;

   ltmd_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_data (req_data),
      .rsp_next (rsp_next)
   );

   ltmd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .rsp_next  (rsp_next),
      .can_load  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/ltmd_parse.sv]
// ----------------------------------------------------------------------------
// Deframer parse stage
// Holds the frame state and the table of nonempty parameter lengths, and
// labels each accepted byte in one pass of logic.
// ----------------------------------------------------------------------------
module ltmd_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  ltmd_pkg::req_type req_data,
   output ltmd_pkg::rsp_type rsp_next
);

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_LEN_HI = 3'd1;
   localparam logic [2:0] PH_LEN_LO = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_TRAIL  = 3'd4;

   logic [2:0]                 phase_ff, phase_in;
   logic [ltmd_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                 hi_hold_ff, hi_hold_in;
   logic [ltmd_pkg::CNT_W-1:0] lens_seen_ff, lens_seen_in;
   logic [ltmd_pkg::CNT_W-1:0] nz_count_ff, nz_count_in;
   logic [ltmd_pkg::CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ltmd_pkg::CNT_W-1:0] cur_param_ff, cur_param_in;
   logic [15:0]                bytes_left_ff, bytes_left_in;
   logic                       overflow_ff, overflow_in;

   // Only nonempty parameters are queued, each with its parameter index, so
   // skipping empty ones is a single lookup at the read pointer.
   logic [15:0]                len_mem [ltmd_pkg::MAX_PARAMS];
   logic [ltmd_pkg::IDX_W-1:0] idx_mem [ltmd_pkg::MAX_PARAMS];
   logic                       mem_we;
   logic [15:0]                word;
   logic [ltmd_pkg::IDX_W-1:0] len_idx;
   logic                       seek;
   logic                       head_ok;
   logic [ltmd_pkg::CNT_W-1:0] rd_ptr_nx;
   logic [15:0]                head_len_ff;
   logic [ltmd_pkg::IDX_W-1:0] head_idx_ff;
   logic [15:0]                head_len;
   logic [ltmd_pkg::IDX_W-1:0] head_idx;
   ltmd_pkg::rsp_type          rsp;

   assign word     = {hi_hold_ff, req_data.in_byte};
   assign len_idx  = (lens_seen_ff < ltmd_pkg::MAX_PARAMS_CNT) ?
                     lens_seen_ff[ltmd_pkg::IDX_W-1:0] : ltmd_pkg::LAST_PARAM_IDX;
   assign head_ok  = rd_ptr_ff < nz_count_ff;
   assign head_len = head_len_ff;
   assign head_idx = head_idx_ff;
   assign rd_ptr_nx = !step ? rd_ptr_ff : (req_data.frame_last ? '0 : rd_ptr_in);

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = (pos_ff == ltmd_pkg::MIN_FRAME) ? pos_ff : pos_ff + 1'b1;
      hi_hold_in    = hi_hold_ff;
      lens_seen_in  = lens_seen_ff;
      nz_count_in   = nz_count_ff;
      rd_ptr_in     = rd_ptr_ff;
      cur_param_in  = cur_param_ff;
      bytes_left_in = bytes_left_ff;
      overflow_in   = overflow_ff;
      mem_we        = 1'b0;
      seek          = 1'b0;

      rsp                 = '0;
      rsp.out_byte        = req_data.in_byte;
      rsp.kind            = ltmd_pkg::KIND_TRAILING;

      case (phase_ff)
         PH_HEADER: begin
            if (pos_ff == '0) begin
               rsp.kind = ltmd_pkg::KIND_TYPE;
            end else if (pos_ff <= ltmd_pkg::LAST_CMD_POS) begin
               rsp.kind = ltmd_pkg::KIND_COMMAND;
            end else begin
               rsp.kind = ltmd_pkg::KIND_VERSION;
            end
            if (pos_ff >= ltmd_pkg::HEADER_BYTES - 1'b1) begin
               phase_in = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            rsp.kind        = ltmd_pkg::KIND_LENGTH;
            rsp.param_index = len_idx;
            hi_hold_in      = req_data.in_byte;
            phase_in        = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            if (word == ltmd_pkg::TERMINATOR_WORD) begin
               rsp.kind = ltmd_pkg::KIND_TERMINATOR;
               seek     = 1'b1;
            end else begin
               rsp.kind        = ltmd_pkg::KIND_LENGTH;
               rsp.param_index = len_idx;
               if (lens_seen_ff < ltmd_pkg::MAX_PARAMS_CNT) begin
                  lens_seen_in = lens_seen_ff + 1'b1;
                  if (word != '0) begin
                     mem_we      = 1'b1;
                     nz_count_in = nz_count_ff + 1'b1;
                  end
               end else begin
                  overflow_in = 1'b1;
               end
               phase_in = PH_LEN_HI;
            end
         end
         PH_DATA: begin
            rsp.kind        = ltmd_pkg::KIND_DATA;
            rsp.param_index = cur_param_ff[ltmd_pkg::IDX_W-1:0];
            bytes_left_in   = bytes_left_ff - 1'b1;
            if (bytes_left_ff == 16'd1) begin
               rsp.param_byte_last = 1'b1;
               seek                = 1'b1;
            end
         end
         default: begin
            rsp.kind = ltmd_pkg::KIND_TRAILING;
            phase_in = PH_TRAIL;
         end
      endcase

      // Move to the next nonempty parameter, or past every stored one.
      if (seek) begin
         if (head_ok) begin
            phase_in      = PH_DATA;
            bytes_left_in = head_len;
            cur_param_in  = {1'b0, head_idx};
            rd_ptr_in     = rd_ptr_ff + 1'b1;
         end else begin
            phase_in     = PH_TRAIL;
            cur_param_in = lens_seen_ff;
         end
      end

      if (req_data.frame_last) begin
         rsp.frame_done = 1'b1;
         if (pos_in < ltmd_pkg::MIN_FRAME) begin
            rsp.status = ltmd_pkg::STATUS_TOO_SHORT;
         end else if (phase_in == PH_HEADER || phase_in == PH_LEN_HI ||
                      phase_in == PH_LEN_LO) begin
            rsp.status = ltmd_pkg::STATUS_NO_TERM;
         end else begin
            rsp.param_count = cur_param_in;
            if (overflow_in) begin
               rsp.status = ltmd_pkg::STATUS_TOO_MANY;
            end else if (phase_in == PH_DATA) begin
               rsp.status = ltmd_pkg::STATUS_TRUNCATED;
            end
         end
      end
   end

   assign rsp_next = rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         pos_ff        <= '0;
         hi_hold_ff    <= '0;
         lens_seen_ff  <= '0;
         nz_count_ff   <= '0;
         rd_ptr_ff     <= '0;
         cur_param_ff  <= '0;
         bytes_left_ff <= '0;
         overflow_ff   <= 1'b0;
      end else if (step) begin
         if (req_data.frame_last) begin
            // The next frame starts from a clean state.
            phase_ff      <= PH_HEADER;
            pos_ff        <= '0;
            hi_hold_ff    <= '0;
            lens_seen_ff  <= '0;
            nz_count_ff   <= '0;
            rd_ptr_ff     <= '0;
            cur_param_ff  <= '0;
            bytes_left_ff <= '0;
            overflow_ff   <= 1'b0;
         end else begin
            phase_ff      <= phase_in;
            pos_ff        <= pos_in;
            hi_hold_ff    <= hi_hold_in;
            lens_seen_ff  <= lens_seen_in;
            nz_count_ff   <= nz_count_in;
            rd_ptr_ff     <= rd_ptr_in;
            cur_param_ff  <= cur_param_in;
            bytes_left_ff <= bytes_left_in;
            overflow_ff   <= overflow_in;
         end
      end
   end

   // The entry at the next read pointer is fetched every cycle. A length is
   // always stored at least one beat before the terminator, and a parameter
   // takes at least one beat, so the fetched entry is current when needed.
   always_ff @(posedge clock) begin
      if (step && mem_we) begin
         len_mem[nz_count_ff[ltmd_pkg::IDX_W-1:0]] <= word;
         idx_mem[nz_count_ff[ltmd_pkg::IDX_W-1:0]] <= lens_seen_ff[ltmd_pkg::IDX_W-1:0];
      end
      head_len_ff <= len_mem[rd_ptr_nx[ltmd_pkg::IDX_W-1:0]];
      head_idx_ff <= idx_mem[rd_ptr_nx[ltmd_pkg::IDX_W-1:0]];
   end

endmodule

[rtl/ltmd_rsp_reg.sv]
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one labelled beat for the result channel and frees the input side
// whenever the held beat is empty or being taken.
// ----------------------------------------------------------------------------
module ltmd_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  ltmd_pkg::rsp_type rsp_next,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ltmd_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   ltmd_pkg::rsp_type data_ff;

   assign can_load  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_next;
      end
   end

endmodule

[rtl/ltmd_checker.sv]
// ----------------------------------------------------------------------------
// Deframer port checker
// Watches the top-level ports for beat ordering and result field rules.
// ----------------------------------------------------------------------------
module ltmd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input ltmd_pkg::rsp_type rsp_data,
   input logic              rsp_valid,
   input logic              rsp_ready
);

   // A stalled result beat must not change or disappear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Every accepted input beat produces a result beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted beat produced no result");

   // With the result register empty the input side must be open.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // Status and count only carry meaning on the closing beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_done |->
         rsp_data.status == ltmd_pkg::STATUS_OK && rsp_data.param_count == '0)
      else $error("status or count set on a beat that does not close the frame");

   // Only parameter data can close a parameter.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.param_byte_last |-> rsp_data.kind == ltmd_pkg::KIND_DATA)
      else $error("parameter end marked on a non-data beat");

endmodule

bind length_table_message_deframer_core ltmd_checker u_ltmd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Length-table message deframer testbench
// Sends directed and random frames through the deframer with random gaps on
// both handshakes, predicts the label of every byte and checks each result
// beat in order against the prediction.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LIMIT_CYCLES  = 1000000;
   localparam int RANDOM_ITEMS  = 1350;
   localparam int SETTLE_CYCLES = 8;
   localparam int DATA_CAP      = 120;
   localparam int SIDE_REQ      = 0;
   localparam int SIDE_RSP      = 1;

   typedef enum logic [2:0] {
      FR_HEADER, FR_LEN_HI, FR_LEN_LO, FR_DATA, FR_TRAIL
   } frame_phase_type;

   // Tracks the deframer's per-frame state and holds the labels still due.
   class label_board_type;
      ltmd_pkg::rsp_type expected_labels[$];
      int                failures;
      logic [15:0]       position;
      frame_phase_type   phase;
      logic [7:0]        length_hi;
      logic [15:0]       lengths [ltmd_pkg::MAX_PARAMS];
      int                n_lengths;
      int                cur_param;
      logic [15:0]       left;
      bit                overflow;

      function new();
         failures = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         position  = '0;
         phase     = FR_HEADER;
         length_hi = '0;
         n_lengths = 0;
         cur_param = 0;
         left      = '0;
         overflow  = 1'b0;
      endfunction

      // Empty parameters are complete at once; skip them.
      function void next_param();
         while (cur_param < n_lengths && lengths[cur_param] == 16'd0) cur_param++;
         if (cur_param < n_lengths) begin
            left  = lengths[cur_param];
            phase = FR_DATA;
         end else begin
            phase = FR_TRAIL;
         end
      endfunction

      function void note_byte(ltmd_pkg::req_type beat);
         ltmd_pkg::rsp_type r;
         logic [15:0]       at;
         logic [15:0]       word;
         int                idx;
         int                last_idx;
         r          = '0;
         r.out_byte = beat.in_byte;
         r.kind     = ltmd_pkg::KIND_TRAILING;
         idx        = 0;
         last_idx   = int'(ltmd_pkg::LAST_PARAM_IDX);
         at         = position;
         if (position != 16'hFFFF) position++;
         case (phase)
            FR_HEADER: begin
               if (at == 16'd0) r.kind = ltmd_pkg::KIND_TYPE;
               else if (int'(at) <= int'(ltmd_pkg::LAST_CMD_POS))
                  r.kind = ltmd_pkg::KIND_COMMAND;
               else r.kind = ltmd_pkg::KIND_VERSION;
               if (int'(at) + 1 >= int'(ltmd_pkg::HEADER_BYTES)) phase = FR_LEN_HI;
            end
            FR_LEN_HI: begin
               r.kind    = ltmd_pkg::KIND_LENGTH;
               idx       = (n_lengths < ltmd_pkg::MAX_PARAMS) ? n_lengths : last_idx;
               length_hi = beat.in_byte;
               phase     = FR_LEN_LO;
            end
            FR_LEN_LO: begin
               word = {length_hi, beat.in_byte};
               if (word == ltmd_pkg::TERMINATOR_WORD) begin
                  r.kind = ltmd_pkg::KIND_TERMINATOR;
                  next_param();
               end else begin
                  r.kind = ltmd_pkg::KIND_LENGTH;
                  idx    = (n_lengths < ltmd_pkg::MAX_PARAMS) ? n_lengths : last_idx;
                  if (n_lengths < ltmd_pkg::MAX_PARAMS) begin
                     lengths[n_lengths] = word;
                     n_lengths++;
                  end else begin
                     overflow = 1'b1;
                  end
                  phase = FR_LEN_HI;
               end
            end
            FR_DATA: begin
               r.kind = ltmd_pkg::KIND_DATA;
               idx    = cur_param;
               if (left != 16'd0) left--;
               if (left == 16'd0) begin
                  r.param_byte_last = 1'b1;
                  cur_param++;
                  next_param();
               end
            end
            default: begin
               r.kind = ltmd_pkg::KIND_TRAILING;
               phase  = FR_TRAIL;
            end
         endcase
         r.param_index = idx[ltmd_pkg::IDX_W-1:0];
         if (beat.frame_last) begin
            r.frame_done = 1'b1;
            if (int'(position) < int'(ltmd_pkg::MIN_FRAME)) begin
               r.status = ltmd_pkg::STATUS_TOO_SHORT;
            end else if (phase == FR_HEADER || phase == FR_LEN_HI ||
                         phase == FR_LEN_LO) begin
               r.status = ltmd_pkg::STATUS_NO_TERM;
            end else begin
               r.param_count = cur_param[ltmd_pkg::CNT_W-1:0];
               if (overflow) r.status = ltmd_pkg::STATUS_TOO_MANY;
               else if (phase == FR_DATA) r.status = ltmd_pkg::STATUS_TRUNCATED;
               else r.status = ltmd_pkg::STATUS_OK;
            end
            clear_frame();
         end
         expected_labels.insert(expected_labels.size(), r);
      endfunction

      function void check_label(ltmd_pkg::rsp_type got);
         ltmd_pkg::rsp_type want;
         if (expected_labels.size() == 0) begin
            failures++;
            $display("%0t: result beat with none expected: got %h", $time, got);
            return;
         end
         want = expected_labels.pop_front();
         if (got !== want) begin
            failures++;
            $display("%0t: mismatch: expected byte %h kind %0d idx %0d last %0b done %0b",
                     $time, want.out_byte, want.kind, want.param_index,
                     want.param_byte_last, want.frame_done,
                     " status %0d count %0d, got byte %h kind %0d idx %0d last %0b",
                     want.status, want.param_count, got.out_byte, got.kind,
                     got.param_index, got.param_byte_last,
                     " done %0b status %0d count %0d",
                     got.frame_done, got.status, got.param_count);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ltmd_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   ltmd_pkg::rsp_type rsp_data;

   label_board_type label_board;
   logic [7:0]      frame_buf[$];
   int              quiet_left [2];
   int              items_sent;
   int              cycles = 0;

   length_table_message_deframer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Mostly short gaps, a few long ones, and now and then a quiet stretch.
   function automatic int idle_cycles(int side);
      int r;
      if (quiet_left[side] > 0) begin
         quiet_left[side]--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         quiet_left[side] = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_beat(ltmd_pkg::req_type beat);
      int gap;
      gap = idle_cycles(SIDE_REQ);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      label_board.note_byte(beat);
      @(negedge clock);
   endtask

   task automatic send_frame();
      ltmd_pkg::req_type beat;
      for (int i = 0; i < frame_buf.size(); i++) begin
         beat.in_byte    = frame_buf[i];
         beat.frame_last = (i == frame_buf.size() - 1);
         send_beat(beat);
         items_sent++;
      end
   endtask

   // Holds the sender off until every predicted result beat has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (label_board.expected_labels.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic append_byte(logic [7:0] b);
      frame_buf.insert(frame_buf.size(), b);
   endtask

   task automatic append_random_byte();
      append_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic append_word(logic [15:0] w);
      append_byte(w[15:8]);
      append_byte(w[7:0]);
   endtask

   task automatic random_frame();
      int          pick;
      int          n_params;
      int          max_len;
      int          n_keep;
      logic [15:0] len;
      logic [15:0] plen[$];
      frame_buf.delete();
      pick     = $urandom_range(0, 99);
      n_params = $urandom_range(0, 6);
      max_len  = ($urandom_range(0, 9) == 0) ? 24 : 5;
      if (pick < 12) n_params = $urandom_range(15, 19);
      repeat (6) append_random_byte();
      for (int i = 0; i < n_params; i++) begin
         len = 16'($urandom_range(0, max_len));
         if (pick >= 12 && pick < 18) len = 16'($urandom_range(0, 16'hFFFE));
         plen.insert(plen.size(), len);
         append_word(len);
      end
      // Leaving out the terminator keeps the frame in the length words.
      if (!(pick >= 36 && pick < 41)) begin
         append_word(ltmd_pkg::TERMINATOR_WORD);
         for (int i = 0; i < plen.size() && i < ltmd_pkg::MAX_PARAMS; i++)
            for (int j = 0; j < plen[i] && frame_buf.size() < DATA_CAP; j++)
               append_random_byte();
         repeat ($urandom_range(0, 3)) append_random_byte();
      end
      if (pick >= 18 && pick < 36) begin
         n_keep = $urandom_range(1, frame_buf.size());
         while (frame_buf.size() > n_keep) void'(frame_buf.pop_back());
      end
      if (pick >= 92) begin
         frame_buf.delete();
         repeat ($urandom_range(1, 20))
            append_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
      end
   endtask

   // Result side: random stalls on ready, independent of the sender.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left = idle_cycles(SIDE_RSP);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) label_board.check_label(rsp_data);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int frames;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      quiet_left  = '{0, 0};
      items_sent  = 0;
      frames      = 0;
      label_board = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty parameter, terminator split over two beats, one data byte.
      frame_buf = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'hFF, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'h3C};
      send_frame();
      // A frame that is too short.
      frame_buf = '{8'h12, 8'h34, 8'h56};
      send_frame();
      // A length word with a high byte of all ones that is not the
      // terminator, then the frame ends inside that parameter.
      frame_buf = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                    8'hFF, 8'h01, 8'hFF, 8'hFF, 8'h40, 8'h80};
      send_frame();
      drain();

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         random_frame();
         send_frame();
         frames++;
         if (frames % 30 == 0) drain();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (label_board.failures == 0 && label_board.expected_labels.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
